FILE: rtl/core/bmlc_pkg.sv
// ----------------------------------------------------------------------------
// bmlc_pkg
// Shared constants, types and helpers for the Lucas/CRT binomial unit.
// ----------------------------------------------------------------------------
`default_nettype none

package bmlc_pkg;

   localparam int ARG_BITS    = 31;
   localparam int PRIME_SMALL = 29;
   localparam int PRIME_LARGE = 34483;   // must be the larger prime
   localparam int VAL_BITS    = 16;      // any residue of either prime
   localparam int RES_BITS    = 20;
   localparam int REQ_DATA_BITS = ((2 * ARG_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((RES_BITS + 7) / 8) * 8;

   localparam logic [31:0] RECIP_SMALL = 32'((64'd1 << 32) / PRIME_SMALL);
   localparam logic [31:0] RECIP_LARGE = 32'((64'd1 << 32) / PRIME_LARGE);

   function automatic int digit_count(input longint unsigned p);
      longint unsigned pw;
      int cnt;
      pw  = 1;
      cnt = 0;
      while (pw < (64'd1 << ARG_BITS)) begin
         pw  = pw * p;
         cnt = cnt + 1;
      end
      return cnt;
   endfunction

   // (PRIME_SMALL)^-1 mod PRIME_LARGE by fermat
   function automatic longint unsigned inv_small_mod_large();
      longint unsigned r;
      longint unsigned b;
      longint unsigned e;
      r = 1;
      b = PRIME_SMALL % PRIME_LARGE;
      e = PRIME_LARGE - 2;
      for (int i = 0; i < 17; i++) begin
         if (e[i]) r = (r * b) % PRIME_LARGE;
         b = (b * b) % PRIME_LARGE;
      end
      return r;
   endfunction

   localparam int NDIG_SMALL = digit_count(PRIME_SMALL);
   localparam int NDIG_LARGE = digit_count(PRIME_LARGE);
   localparam int NDIG_MAX   = (NDIG_SMALL > NDIG_LARGE) ? NDIG_SMALL : NDIG_LARGE;
   localparam int DIDX_BITS  = (NDIG_MAX > 1) ? $clog2(NDIG_MAX) : 1;
   localparam int CHAIN_LAT  = 2 * NDIG_MAX;
   localparam int SETTLE_BITS = $clog2(CHAIN_LAT + 1);

   localparam int TABLE_DEPTH = PRIME_LARGE + PRIME_SMALL;
   localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
   localparam int SMALL_BASE  = PRIME_LARGE;

   localparam logic [VAL_BITS-1:0] INV_SMALL = VAL_BITS'(inv_small_mod_large());
   localparam logic [RES_BITS-1:0] MODULUS   = RES_BITS'(PRIME_SMALL * PRIME_LARGE);

   typedef enum logic {
      PRIME_SEL_SMALL,
      PRIME_SEL_LARGE
   } prime_sel_type;

   typedef struct packed {
      logic                start;
      prime_sel_type       sel;
      logic [VAL_BITS-1:0] a;
      logic [VAL_BITS-1:0] b;
   } mm_req_type;

   function automatic logic [VAL_BITS-1:0] prime_value(input prime_sel_type sel);
      return (sel == PRIME_SEL_LARGE) ? VAL_BITS'(PRIME_LARGE) : VAL_BITS'(PRIME_SMALL);
   endfunction

   function automatic logic [31:0] prime_recip(input prime_sel_type sel);
      return (sel == PRIME_SEL_LARGE) ? RECIP_LARGE : RECIP_SMALL;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/bmlc_digit_cell.sv
// ----------------------------------------------------------------------------
// bmlc_digit_cell
// One link of the digit chain: splits n and m into low base-p digit and
// quotient, handing the quotients to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module bmlc_digit_cell (
   input  logic                               clock,
   input  bmlc_pkg::prime_sel_type            prime_sel,
   input  logic [bmlc_pkg::ARG_BITS-1:0]      n_in,
   input  logic [bmlc_pkg::ARG_BITS-1:0]      m_in,
   output logic [bmlc_pkg::ARG_BITS-1:0]      n_quo,
   output logic [bmlc_pkg::ARG_BITS-1:0]      m_quo,
   output logic [bmlc_pkg::VAL_BITS-1:0]      n_dig,
   output logic [bmlc_pkg::VAL_BITS-1:0]      m_dig
);
   import bmlc_pkg::*;

   logic [ARG_BITS-1:0] x_in     [2];
   logic [ARG_BITS-1:0] x_ff     [2];
   logic [ARG_BITS-1:0] q0_in    [2];
   logic [ARG_BITS-1:0] q0_ff    [2];
   logic [ARG_BITS-1:0] quo_in   [2];
   logic [ARG_BITS-1:0] quo_ff   [2];
   logic [VAL_BITS-1:0] dig_in   [2];
   logic [VAL_BITS-1:0] dig_ff   [2];
   logic [63:0]         prod     [2];
   logic [ARG_BITS+VAL_BITS-1:0] qp [2];
   logic [ARG_BITS-1:0] rem_wide [2];
   logic [VAL_BITS:0]   rem      [2];
   logic [VAL_BITS-1:0] p_val;

   assign x_in[0] = n_in;
   assign x_in[1] = m_in;
   assign p_val   = prime_value(prime_sel);

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         // quotient estimate by reciprocal, low by at most one
         prod[i]  = {{(64-ARG_BITS){1'b0}}, x_in[i]} * {32'd0, prime_recip(prime_sel)};
         q0_in[i] = prod[i][32 +: ARG_BITS];
         qp[i]    = {{VAL_BITS{1'b0}}, q0_ff[i]} * {{ARG_BITS{1'b0}}, p_val};
         rem_wide[i] = x_ff[i] - qp[i][ARG_BITS-1:0];
         rem[i]   = rem_wide[i][VAL_BITS:0];
         if (rem[i] >= {1'b0, p_val}) begin
            quo_in[i] = q0_ff[i] + ARG_BITS'(1);
            dig_in[i] = VAL_BITS'(rem[i] - {1'b0, p_val});
         end else begin
            quo_in[i] = q0_ff[i];
            dig_in[i] = rem[i][VAL_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 2; i++) begin
         x_ff[i]   <= x_in[i];
         q0_ff[i]  <= q0_in[i];
         quo_ff[i] <= quo_in[i];
         dig_ff[i] <= dig_in[i];
      end
   end

   assign n_quo = quo_ff[0];
   assign m_quo = quo_ff[1];
   assign n_dig = dig_ff[0];
   assign m_dig = dig_ff[1];

endmodule

`default_nettype wire

FILE: rtl/core/bmlc_modmul.sv
// ----------------------------------------------------------------------------
// bmlc_modmul
// Three-stage modular multiplier for either prime: product, reciprocal
// quotient estimate, remainder with one correction.
// ----------------------------------------------------------------------------
`default_nettype none

module bmlc_modmul (
   input  logic                          clock,
   input  logic                          reset,
   input  bmlc_pkg::mm_req_type          mm_req,
   output logic                          mm_valid,
   output logic [bmlc_pkg::VAL_BITS-1:0] mm_res
);
   import bmlc_pkg::*;

   logic [2:0]          vld_ff;
   logic [31:0]         prod_ff;
   prime_sel_type       sel1_ff;
   prime_sel_type       sel2_ff;
   logic [31:0]         x2_ff;
   logic [31:0]         q0_ff;
   logic [VAL_BITS-1:0] res_ff;
   logic [63:0]         est;
   logic [47:0]         qp;
   logic [31:0]         rem_wide;
   logic [VAL_BITS:0]   rem;
   logic [VAL_BITS-1:0] p_val;

   assign est      = {32'd0, prod_ff} * {32'd0, prime_recip(sel1_ff)};
   assign p_val    = prime_value(sel2_ff);
   assign qp       = {16'd0, q0_ff} * {32'd0, p_val};
   assign rem_wide = x2_ff - qp[31:0];
   assign rem      = rem_wide[VAL_BITS:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[1:0], mm_req.start};
      end
      prod_ff <= {16'd0, mm_req.a} * {16'd0, mm_req.b};
      sel1_ff <= mm_req.sel;
      x2_ff   <= prod_ff;
      q0_ff   <= est[63:32];
      sel2_ff <= sel1_ff;
      if (rem >= {1'b0, p_val}) begin
         res_ff <= VAL_BITS'(rem - {1'b0, p_val});
      end else begin
         res_ff <= rem[VAL_BITS-1:0];
      end
   end

   assign mm_valid = vld_ff[2];
   assign mm_res   = res_ff;

endmodule

`default_nettype wire

FILE: rtl/core/binomial_mod_lucas_crt.sv
// ----------------------------------------------------------------------------
// binomial_mod_lucas_crt
// C(n, m) mod 29*34483 by Lucas digits per prime, joined by CRT.
// ----------------------------------------------------------------------------
// req channel: one word per (n, m) pair; rsp channel: one word per result.
// After reset the block builds its factorial and inverse-factorial tables in
// internal memory, one entry at a time through the modular multiplier, with
// req_tready low. Then one item is worked at a time: the digit cell chain
// settles; each digit pair (7 digits base 29, 3 digits base 34483) takes one
// table read and three multiplies in the shared 3-stage modular multiplier;
// last come the CRT join and output. A digit of m above its n digit ends that
// prime's product early with a zero residue; m above n gives a zero result.
// The result sits in an output register: the next word is accepted while it
// waits; if the receiver stalls the finished result of the next item waits
// until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module binomial_mod_lucas_crt (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [30:0] n_total, [61:31] k_choose
   input  logic [bmlc_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [19:0] binom_residue
   output logic [bmlc_pkg::RSP_DATA_BITS-1:0]  rsp_tdata
);
   import bmlc_pkg::*;

   typedef enum logic [3:0] {
      ST_FILL_FACT,
      ST_FILL_FACT_WAIT,
      ST_FILL_INV,
      ST_FILL_INV_WAIT,
      ST_IDLE,
      ST_SETTLE,
      ST_LOOKUP,
      ST_MUL,
      ST_MUL_WAIT,
      ST_CRT,
      ST_CRT_WAIT,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      STEP_FACT_INV,
      STEP_INV,
      STEP_ACC
   } step_type;

   state_type           state_ff;
   step_type            step_ff;
   prime_sel_type       phase_ff;
   logic [ARG_BITS-1:0] n_hold_ff;
   logic [ARG_BITS-1:0] m_hold_ff;
   logic                gt_ff;
   logic [SETTLE_BITS-1:0] settle_ff;
   logic [DIDX_BITS-1:0] didx_ff;
   logic [VAL_BITS-1:0] acc_ff;
   logic [VAL_BITS-1:0] t_ff;
   logic [VAL_BITS-1:0] res_small_ff;
   logic [VAL_BITS-1:0] k_ff;
   logic [VAL_BITS-1:0] fill_idx_ff;
   logic [VAL_BITS-1:0] fill_val_ff;
   logic                rsp_valid_ff;
   logic [RES_BITS-1:0] rsp_res_ff;

   logic [VAL_BITS-1:0] fact_mem  [TABLE_DEPTH];
   logic [VAL_BITS-1:0] ifact_mem [TABLE_DEPTH];
   logic [VAL_BITS-1:0] fact_rd_ff;
   logic [VAL_BITS-1:0] inv_a_ff;
   logic [VAL_BITS-1:0] inv_b_ff;

   // digit chain wiring
   logic [ARG_BITS-1:0] sn_q [NDIG_SMALL];
   logic [ARG_BITS-1:0] sm_q [NDIG_SMALL];
   logic [ARG_BITS-1:0] ln_q [NDIG_LARGE];
   logic [ARG_BITS-1:0] lm_q [NDIG_LARGE];
   logic [VAL_BITS-1:0] sn_dig [NDIG_MAX];
   logic [VAL_BITS-1:0] sm_dig [NDIG_MAX];
   logic [VAL_BITS-1:0] ln_dig [NDIG_MAX];
   logic [VAL_BITS-1:0] lm_dig [NDIG_MAX];

   genvar k;
   generate
      for (k = 0; k < NDIG_MAX; k++) begin : g_small
         if (k < NDIG_SMALL) begin : g_cell
            if (k == 0) begin : g_first
               bmlc_digit_cell u_cell (
                  .clock(clock), .prime_sel(PRIME_SEL_SMALL),
                  .n_in(n_hold_ff), .m_in(m_hold_ff),
                  .n_quo(sn_q[k]), .m_quo(sm_q[k]),
                  .n_dig(sn_dig[k]), .m_dig(sm_dig[k])
               );
            end else begin : g_next
               bmlc_digit_cell u_cell (
                  .clock(clock), .prime_sel(PRIME_SEL_SMALL),
                  .n_in(sn_q[k-1]), .m_in(sm_q[k-1]),
                  .n_quo(sn_q[k]), .m_quo(sm_q[k]),
                  .n_dig(sn_dig[k]), .m_dig(sm_dig[k])
               );
            end
         end else begin : g_pad
            assign sn_dig[k] = '0;
            assign sm_dig[k] = '0;
         end
      end
      for (k = 0; k < NDIG_MAX; k++) begin : g_large
         if (k < NDIG_LARGE) begin : g_cell
            if (k == 0) begin : g_first
               bmlc_digit_cell u_cell (
                  .clock(clock), .prime_sel(PRIME_SEL_LARGE),
                  .n_in(n_hold_ff), .m_in(m_hold_ff),
                  .n_quo(ln_q[k]), .m_quo(lm_q[k]),
                  .n_dig(ln_dig[k]), .m_dig(lm_dig[k])
               );
            end else begin : g_next
               bmlc_digit_cell u_cell (
                  .clock(clock), .prime_sel(PRIME_SEL_LARGE),
                  .n_in(ln_q[k-1]), .m_in(lm_q[k-1]),
                  .n_quo(ln_q[k]), .m_quo(lm_q[k]),
                  .n_dig(ln_dig[k]), .m_dig(lm_dig[k])
               );
            end
         end else begin : g_pad
            assign ln_dig[k] = '0;
            assign lm_dig[k] = '0;
         end
      end
   endgenerate

   // modular multiplier
   mm_req_type          mm_req;
   logic                mm_valid;
   logic [VAL_BITS-1:0] mm_res;

   bmlc_modmul u_modmul (
      .clock(clock), .reset(reset), .mm_req(mm_req),
      .mm_valid(mm_valid), .mm_res(mm_res)
   );

   logic [VAL_BITS-1:0]  dn;
   logic [VAL_BITS-1:0]  dm;
   logic [ADDR_BITS-1:0] base;
   logic [VAL_BITS-1:0]  p_last;
   logic [DIDX_BITS-1:0] didx_last;
   logic [VAL_BITS:0]    crt_sum;
   logic [VAL_BITS-1:0]  crt_diff;
   logic [RES_BITS-1:0]  crt_out;

   assign dn = (phase_ff == PRIME_SEL_LARGE) ? ln_dig[didx_ff] : sn_dig[didx_ff];
   assign dm = (phase_ff == PRIME_SEL_LARGE) ? lm_dig[didx_ff] : sm_dig[didx_ff];
   assign base = (phase_ff == PRIME_SEL_LARGE) ? '0 : ADDR_BITS'(SMALL_BASE);
   assign p_last = prime_value(phase_ff) - VAL_BITS'(1);
   assign didx_last = (phase_ff == PRIME_SEL_LARGE) ? DIDX_BITS'(NDIG_LARGE - 1)
                                                    : DIDX_BITS'(NDIG_SMALL - 1);
   // (b - a) mod p_large, a is below the smaller prime
   assign crt_sum  = {1'b0, acc_ff} + (VAL_BITS+1)'(PRIME_LARGE) - {1'b0, res_small_ff};
   assign crt_diff = (crt_sum >= (VAL_BITS+1)'(PRIME_LARGE))
                     ? VAL_BITS'(crt_sum - (VAL_BITS+1)'(PRIME_LARGE))
                     : crt_sum[VAL_BITS-1:0];
   assign crt_out = RES_BITS'(res_small_ff)
                  + RES_BITS'({16'd0, k_ff} * 32'(PRIME_SMALL));

   always_comb begin
      mm_req.start = 1'b0;
      mm_req.sel   = phase_ff;
      mm_req.a     = fill_val_ff;
      mm_req.b     = fill_idx_ff;
      unique case (state_ff)
         ST_FILL_FACT: begin
            mm_req.start = 1'b1;
            mm_req.b     = VAL_BITS'(fill_idx_ff + VAL_BITS'(1));
         end
         ST_FILL_INV: begin
            mm_req.start = 1'b1;
         end
         ST_MUL: begin
            mm_req.start = 1'b1;
            unique case (step_ff)
               STEP_FACT_INV: begin
                  mm_req.a = fact_rd_ff;
                  mm_req.b = inv_a_ff;
               end
               STEP_INV: begin
                  mm_req.a = t_ff;
                  mm_req.b = inv_b_ff;
               end
               default: begin
                  mm_req.a = acc_ff;
                  mm_req.b = t_ff;
               end
            endcase
         end
         ST_CRT: begin
            mm_req.start = 1'b1;
            mm_req.sel   = PRIME_SEL_LARGE;
            mm_req.a     = crt_diff;
            mm_req.b     = INV_SMALL;
         end
         default: begin
            mm_req.start = 1'b0;
         end
      endcase
   end

   // table memories
   always_ff @(posedge clock) begin
      if (state_ff == ST_FILL_FACT) begin
         fact_mem[ADDR_BITS'(base + ADDR_BITS'(fill_idx_ff))] <= fill_val_ff;
      end
      if (state_ff == ST_FILL_INV) begin
         ifact_mem[ADDR_BITS'(base + ADDR_BITS'(fill_idx_ff))] <= fill_val_ff;
      end
      if (state_ff == ST_LOOKUP) begin
         fact_rd_ff <= fact_mem[ADDR_BITS'(base + ADDR_BITS'(dn))];
         inv_a_ff   <= ifact_mem[ADDR_BITS'(base + ADDR_BITS'(dm))];
         inv_b_ff   <= ifact_mem[ADDR_BITS'(base + ADDR_BITS'(dn - dm))];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL_FACT;
         phase_ff     <= PRIME_SEL_LARGE;
         fill_idx_ff  <= '0;
         fill_val_ff  <= VAL_BITS'(1);
         rsp_valid_ff <= 1'b0;
         step_ff      <= STEP_FACT_INV;
         settle_ff    <= '0;
         didx_ff      <= '0;
         gt_ff        <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && state_ff != ST_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_FILL_FACT: begin
               state_ff <= ST_FILL_FACT_WAIT;
            end
            ST_FILL_FACT_WAIT: begin
               if (mm_valid) begin
                  fill_val_ff <= mm_res;
                  if (fill_idx_ff == p_last) begin
                     if (phase_ff == PRIME_SEL_LARGE) begin
                        phase_ff    <= PRIME_SEL_SMALL;
                        fill_idx_ff <= '0;
                        fill_val_ff <= VAL_BITS'(1);
                        state_ff    <= ST_FILL_FACT;
                     end else begin
                        // inverse of (p-1)! is p-1 by wilson
                        phase_ff    <= PRIME_SEL_LARGE;
                        fill_idx_ff <= VAL_BITS'(PRIME_LARGE - 1);
                        fill_val_ff <= VAL_BITS'(PRIME_LARGE - 1);
                        state_ff    <= ST_FILL_INV;
                     end
                  end else begin
                     fill_idx_ff <= VAL_BITS'(fill_idx_ff + VAL_BITS'(1));
                     state_ff    <= ST_FILL_FACT;
                  end
               end
            end
            ST_FILL_INV: begin
               state_ff <= ST_FILL_INV_WAIT;
            end
            ST_FILL_INV_WAIT: begin
               if (mm_valid) begin
                  fill_val_ff <= mm_res;
                  if (fill_idx_ff == '0) begin
                     if (phase_ff == PRIME_SEL_LARGE) begin
                        phase_ff    <= PRIME_SEL_SMALL;
                        fill_idx_ff <= VAL_BITS'(PRIME_SMALL - 1);
                        fill_val_ff <= VAL_BITS'(PRIME_SMALL - 1);
                        state_ff    <= ST_FILL_INV;
                     end else begin
                        state_ff <= ST_IDLE;
                     end
                  end else begin
                     fill_idx_ff <= VAL_BITS'(fill_idx_ff - VAL_BITS'(1));
                     state_ff    <= ST_FILL_INV;
                  end
               end
            end
            ST_IDLE: begin
               if (req_tvalid) begin
                  n_hold_ff <= req_tdata[ARG_BITS-1:0];
                  m_hold_ff <= req_tdata[2*ARG_BITS-1:ARG_BITS];
                  gt_ff     <= req_tdata[2*ARG_BITS-1:ARG_BITS] > req_tdata[ARG_BITS-1:0];
                  settle_ff <= '0;
                  phase_ff  <= PRIME_SEL_SMALL;
                  didx_ff   <= '0;
                  acc_ff    <= VAL_BITS'(1);
                  state_ff  <= ST_SETTLE;
               end
            end
            ST_SETTLE: begin
               settle_ff <= SETTLE_BITS'(settle_ff + SETTLE_BITS'(1));
               if (settle_ff == SETTLE_BITS'(CHAIN_LAT - 1)) begin
                  state_ff <= ST_LOOKUP;
               end
            end
            ST_LOOKUP: begin
               if (dm > dn) begin
                  // this prime's residue is zero, the other prime still counts
                  if (phase_ff == PRIME_SEL_SMALL) begin
                     res_small_ff <= '0;
                     phase_ff     <= PRIME_SEL_LARGE;
                     didx_ff      <= '0;
                     acc_ff       <= VAL_BITS'(1);
                  end else begin
                     acc_ff   <= '0;
                     state_ff <= ST_CRT;
                  end
               end else begin
                  step_ff  <= STEP_FACT_INV;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               state_ff <= ST_MUL_WAIT;
            end
            ST_MUL_WAIT: begin
               if (mm_valid) begin
                  unique case (step_ff)
                     STEP_FACT_INV: begin
                        t_ff     <= mm_res;
                        step_ff  <= STEP_INV;
                        state_ff <= ST_MUL;
                     end
                     STEP_INV: begin
                        t_ff     <= mm_res;
                        step_ff  <= STEP_ACC;
                        state_ff <= ST_MUL;
                     end
                     default: begin
                        acc_ff <= mm_res;
                        if (didx_ff == didx_last) begin
                           if (phase_ff == PRIME_SEL_SMALL) begin
                              res_small_ff <= mm_res;
                              phase_ff     <= PRIME_SEL_LARGE;
                              didx_ff      <= '0;
                              acc_ff       <= VAL_BITS'(1);
                              state_ff     <= ST_LOOKUP;
                           end else begin
                              state_ff <= ST_CRT;
                           end
                        end else begin
                           didx_ff  <= DIDX_BITS'(didx_ff + DIDX_BITS'(1));
                           state_ff <= ST_LOOKUP;
                        end
                     end
                  endcase
               end
            end
            ST_CRT: begin
               state_ff <= ST_CRT_WAIT;
            end
            ST_CRT_WAIT: begin
               if (mm_valid) begin
                  k_ff     <= mm_res;
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_res_ff   <= gt_ff ? '0 : crt_out;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_BITS-RES_BITS){1'b0}}, rsp_res_ff};

`ifndef SYNTH
   a_res_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_res_ff < MODULUS))
      else $error("result not below the modulus");

   a_mm_only_when_waiting: assert property (@(posedge clock) disable iff (reset)
      mm_valid |-> (state_ff == ST_FILL_FACT_WAIT || state_ff == ST_FILL_INV_WAIT ||
                    state_ff == ST_MUL_WAIT || state_ff == ST_CRT_WAIT))
      else $error("multiplier result with nobody waiting");

   a_small_residue: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CRT) |-> (res_small_ff < VAL_BITS'(PRIME_SMALL)))
      else $error("small residue out of range at crt join");

   a_no_accept_in_fill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL_FACT || state_ff == ST_FILL_INV) |-> !req_tready)
      else $error("input taken during table build");
`endif

endmodule

`default_nettype wire

FILE: sim/binomial_mod_lucas_crt_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binomial_mod_lucas_crt_checker
// Watches the req and rsp channels of the binomial unit, works out
// C(n, m) mod 29*34483 for every accepted req word and compares each rsp word
// with the oldest outstanding residue.
// ----------------------------------------------------------------------------
`default_nettype none

module binomial_mod_lucas_crt_checker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   input  wire logic                                req_tready,
   // [30:0] n_total, [61:31] k_choose
   input  wire logic [bmlc_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   input  wire logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [19:0] binom_residue
   input  wire logic [bmlc_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   output int                                       fail_count,
   output int                                       residues_pending
);

   import bmlc_pkg::*;

   localparam longint unsigned CRT_COEF_SMALL = 517245;
   localparam longint unsigned CRT_COEF_LARGE = 482763;
   localparam longint unsigned FULL_MODULUS   = 1000007;

   int unsigned fact_sm[PRIME_SMALL];
   int unsigned ifact_sm[PRIME_SMALL];
   int unsigned fact_lg[PRIME_LARGE];
   int unsigned ifact_lg[PRIME_LARGE];
   logic [RES_BITS-1:0] residue_queue[$];

   function automatic longint unsigned power_mod(input longint unsigned b,
                                                 input longint unsigned e,
                                                 input longint unsigned p);
      longint unsigned r;
      r = 1;
      b = b % p;
      while (e > 0) begin
         if (e[0]) r = (r * b) % p;
         b = (b * b) % p;
         e = e >> 1;
      end
      return r;
   endfunction

   // product of digit binomials in base p, zero once an m digit passes its n digit
   function automatic longint unsigned lucas_residue(input longint unsigned n,
                                                     input longint unsigned m,
                                                     input bit use_large);
      longint unsigned p, r, dn, dm, t;
      p = use_large ? PRIME_LARGE : PRIME_SMALL;
      r = 1;
      while (n > 0 || m > 0) begin
         dn = n % p;
         dm = m % p;
         if (dm > dn) return 0;
         if (use_large)
            t = (((longint'(fact_lg[dn]) * ifact_lg[dm]) % p) * ifact_lg[dn - dm]) % p;
         else
            t = (((longint'(fact_sm[dn]) * ifact_sm[dm]) % p) * ifact_sm[dn - dm]) % p;
         r = (r * t) % p;
         n = n / p;
         m = m / p;
      end
      return r;
   endfunction

   function automatic logic [RES_BITS-1:0] binom_mod(input logic [ARG_BITS-1:0] n,
                                                     input logic [ARG_BITS-1:0] m);
      longint unsigned a, b;
      if (m > n) return '0;
      a = lucas_residue(n, m, 1'b0);
      b = lucas_residue(n, m, 1'b1);
      return RES_BITS'(((a * CRT_COEF_SMALL) % FULL_MODULUS
                        + (b * CRT_COEF_LARGE) % FULL_MODULUS) % FULL_MODULUS);
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t checker: %s", $realtime, what);
      fail_count = fail_count + 1;
   endtask

   initial begin
      longint unsigned f;
      fail_count = 0;
      f = 1;
      for (int i = 0; i < PRIME_SMALL; i++) begin
         if (i > 0) f = (f * i) % PRIME_SMALL;
         fact_sm[i] = f;
      end
      ifact_sm[PRIME_SMALL-1] = power_mod(f, PRIME_SMALL - 2, PRIME_SMALL);
      for (int i = PRIME_SMALL - 1; i > 0; i--)
         ifact_sm[i-1] = (longint'(ifact_sm[i]) * i) % PRIME_SMALL;
      f = 1;
      for (int i = 0; i < PRIME_LARGE; i++) begin
         if (i > 0) f = (f * i) % PRIME_LARGE;
         fact_lg[i] = f;
      end
      ifact_lg[PRIME_LARGE-1] = power_mod(f, PRIME_LARGE - 2, PRIME_LARGE);
      for (int i = PRIME_LARGE - 1; i > 0; i--)
         ifact_lg[i-1] = (longint'(ifact_lg[i]) * i) % PRIME_LARGE;
   end

   assign residues_pending = residue_queue.size();

   always @(posedge clock) begin
      logic [RES_BITS-1:0] want;
      if (!reset) begin
         if (req_tvalid && req_tready)
            residue_queue.push_back(binom_mod(req_tdata[ARG_BITS-1:0],
                                              req_tdata[2*ARG_BITS-1:ARG_BITS]));
         if (rsp_tvalid && rsp_tready) begin
            if (residue_queue.size() == 0) begin
               report_mismatch($sformatf("unexpected word residue=%0d",
                                         rsp_tdata[RES_BITS-1:0]));
            end else begin
               want = residue_queue.pop_front();
               if (rsp_tdata[RES_BITS-1:0] !== want)
                  report_mismatch($sformatf("binom_residue got %0d want %0d",
                                            rsp_tdata[RES_BITS-1:0], want));
            end
         end
      end
   end

endmodule

`default_nettype wire

FILE: sim/binomial_mod_lucas_crt_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// binomial_mod_lucas_crt_tb
// Drives (n, m) pairs into the binomial unit with random gaps and rsp stalls:
// directed corners first, then random pairs biased toward m <= n; the
// checker beside the block predicts and compares every residue.
// ----------------------------------------------------------------------------
`default_nettype none

module binomial_mod_lucas_crt_tb;

   import bmlc_pkg::*;

   localparam int RANDOM_PAIRS = 1600;
   localparam int IDLE_LIMIT   = 1500000;   // covers the table build after reset
   localparam int DRAIN_CYCLES = 400;
   localparam logic [ARG_BITS-1:0] ARG_MAX = '1;

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [REQ_DATA_BITS-1:0]  req_tdata;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;
   int                        fail_count;
   int                        residues_pending;
   int                        idle_cycles;
   bit                        send_busy_stretch;
   bit                        recv_busy_stretch;

   binomial_mod_lucas_crt u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   binomial_mod_lucas_crt_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .fail_count       (fail_count),
      .residues_pending (residues_pending)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("binomial_mod_lucas_crt_tb: done, errors");
         $finish;
      end
   end

   task automatic send_pair(input logic [ARG_BITS-1:0] n, input logic [ARG_BITS-1:0] m);
      int gap;
      if ($urandom_range(0, 63) == 0) send_busy_stretch = !send_busy_stretch;
      gap = send_busy_stretch ? $urandom_range(0, 8) : 0;
      repeat (gap) @(negedge clock) req_tvalid <= 1'b0;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_DATA_BITS - 2 * ARG_BITS){1'b0}}, m, n};
      do @(posedge clock); while (!req_tready);
   endtask

   // receiver: one stall draw per word
   initial begin
      int stall;
      rsp_tready = 1'b0;
      forever begin
         if ($urandom_range(0, 63) == 0) recv_busy_stretch = !recv_busy_stretch;
         stall = recv_busy_stretch ? $urandom_range(0, 8) : 0;
         repeat (stall) @(negedge clock) rsp_tready <= 1'b0;
         @(negedge clock) rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   initial begin
      logic [ARG_BITS-1:0] n, m;
      int unsigned w;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      idle_cycles = 0;
      send_busy_stretch = 1'b1;
      recv_busy_stretch = 1'b1;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // corners: zeros, all ones, m > n, digit of m above digit of n
      send_pair(0, 0);
      send_pair(ARG_MAX, ARG_MAX);
      send_pair(ARG_MAX, 0);
      send_pair(0, ARG_MAX);
      send_pair(ARG_MAX, ARG_MAX - 1);
      send_pair(ARG_MAX - 1, ARG_MAX);
      send_pair(5, 6);
      send_pair(28, 14);
      send_pair(29, 1);
      send_pair(29, 29);
      send_pair(34483, 1);
      send_pair(34482, 17241);
      send_pair(34483 * 2, 34483);
      send_pair(1000007, 29);
      send_pair(1000006, 500003);
      send_pair(841 * 28 + 28, 841 * 14 + 5);
      send_pair(31'h2AAAAAAA, 31'h15555555);
      send_pair(31'h55555555, 31'h2AAAAAAA);
      send_pair(1189078289, 34483);
      send_pair(1189078289 - 1, 1189078289 / 2);
      send_pair(ARG_MAX, 31'h40000000);

      for (int i = 0; i < RANDOM_PAIRS; i++) begin
         w = $urandom_range(1, ARG_BITS);
         n = ARG_BITS'($urandom) & ARG_BITS'((64'd1 << w) - 1);
         case ($urandom_range(0, 9))
            0, 1: begin
               n = ARG_BITS'($urandom);
               m = ARG_BITS'($urandom);
            end
            2, 3, 4, 5: m = ARG_BITS'($urandom_range(0, n));
            6: m = (n > 40) ? n - ARG_BITS'($urandom_range(0, 40)) : n;
            7: begin
               n = ARG_BITS'($urandom_range(0, 2000));
               m = ARG_BITS'($urandom_range(0, n));
            end
            8: begin
               n = ARG_BITS'($urandom_range(1, 60000) * (($urandom_range(0, 1) != 0)
                   ? 34483 : 29));
               m = ARG_BITS'($urandom_range(0, n));
            end
            default: m = n & ARG_BITS'($urandom);
         endcase
         send_pair(n, m);
      end
      @(negedge clock) req_tvalid <= 1'b0;

      while (residues_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("binomial_mod_lucas_crt_tb: done, clean");
      else
         $display("binomial_mod_lucas_crt_tb: done, errors");
      $finish;
   end

endmodule

`default_nettype wire

FILE: binomial_mod_lucas_crt.f
rtl/core/bmlc_pkg.sv
rtl/core/bmlc_digit_cell.sv
rtl/core/bmlc_modmul.sv
rtl/core/binomial_mod_lucas_crt.sv
sim/binomial_mod_lucas_crt_checker.sv
sim/binomial_mod_lucas_crt_tb.sv
